/* hdl/fcw_pkg.sv */
// shared types, codes and constants of the fat12 cluster chain walker
package fcw_pkg;

	localparam int TABLE_BYTES_DEF = 8192;

	// cluster size and table bound both fit 13 x 8 bit products
	localparam int LIMIT_W = 21;

	localparam logic [11:0] END_MARK  = 12'hFF8;
	localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

	localparam logic [15:0] RST_DATA_START = 16'd33;
	localparam logic [7:0]  RST_SPC        = 8'd1;
	localparam logic [12:0] RST_BPS        = 13'd512;
	localparam logic [7:0]  RST_SPF        = 8'd9;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_START   = 2'd1,
		OP_ADVANCE = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_DATA_START = 2'd0,
		CFG_SPC        = 2'd1,
		CFG_BPS        = 2'd2,
		CFG_SPF        = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [15:0]        data_start;
		logic [7:0]         spc;
		logic [LIMIT_W-1:0] cluster_size;
		logic [LIMIT_W-1:0] limit;
	} geom_t;

	typedef struct packed {
		logic [11:0] cluster;
		logic [31:0] remaining;
		logic        active;
	} chain_t;

	typedef struct packed {
		logic [11:0] cluster;
		logic [31:0] sector_address;
		logic [19:0] byte_count;
		logic        last;
		logic        table_overrun;
		logic        idle;
	} record_t;

endpackage

/* hdl/fat12_cluster_chain_walker.sv */
// top level of the fat12 cluster chain walker
//
// Items arrive on the item channel (item_valid / item_stall) and are taken at
// an edge with item_valid high and item_stall low. A load writes one table
// byte and a start sets the cluster and byte count. An advance gives one
// record on the result channel (result_valid / result_stall): the beat sets
// adv_valid_s1, and the record is registered in rec_q once the result
// register is free. An advance holds the input until it is finished, since
// the following advance needs the entry pair read from the table at the
// cluster this one decodes, so no item is taken while an advance is pending;
// loads and starts are taken at one per cycle otherwise. A finished record
// waits in the result register while the input keeps taking items; an advance
// only stalls behind a record that is still held. Reset clears the chain state
// and the configuration to its defaults; the table store has no reset and
// needs no clearing pass. Configuration writes go through cfg_write /
// cfg_index / cfg_data and take effect at once.
module fat12_cluster_chain_walker #(
	parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [12:0] table_address,
	input  logic [7:0]  table_byte,
	input  logic [11:0] first_cluster,
	input  logic [31:0] file_length,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [11:0] cluster,
	output logic [31:0] sector_address,
	output logic [19:0] byte_count,
	output logic        last,
	output logic        table_overrun,
	output logic        idle
);
	import fcw_pkg::*;

	localparam int AW = $clog2(TABLE_BYTES);

	geom_t         geom;
	chain_t        chain_q, chain_next;
	record_t       rec, rec_q;
	logic          adv_valid_s1;
	logic          result_valid_q;
	logic          accept, adv_done;
	logic          table_we;
	logic [12:0]   entry_index;
	logic [7:0]    rd_lo, rd_hi;

	fcw_cfg #(.TABLE_BYTES(TABLE_BYTES)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	assign table_we = accept && (opcode_t'(opcode) == OP_LOAD)
		&& ({19'b0, table_address} < TABLE_BYTES);

	fcw_table #(.TABLE_BYTES(TABLE_BYTES)) u_table (
		.clk   (clk),
		.we    (table_we),
		.waddr (AW'(table_address)),
		.wdata (table_byte),
		.raddr (AW'(entry_index)),
		.rd_lo (rd_lo),
		.rd_hi (rd_hi)
	);

	fcw_step u_step (
		.chain       (chain_q),
		.geom        (geom),
		.rd_lo       (rd_lo),
		.rd_hi       (rd_hi),
		.entry_index (entry_index),
		.rec         (rec),
		.chain_next  (chain_next)
	);

	// the table is read every cycle at the current cluster, so the pair is
	// ready in the cycle after an advance beat
	assign item_stall = adv_valid_s1;
	assign accept     = item_valid && !item_stall;
	assign adv_done   = adv_valid_s1 && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else if (accept && (opcode_t'(opcode) == OP_START)) begin
			chain_q.cluster   <= first_cluster;
			chain_q.remaining <= file_length;
			chain_q.active    <= (file_length != 32'd0) && (first_cluster < END_MARK);
		end else if (adv_done) begin
			chain_q <= chain_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_valid_s1   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept && (opcode_t'(opcode) == OP_ADVANCE)) begin
				adv_valid_s1 <= 1'b1;
			end else if (adv_done) begin
				adv_valid_s1 <= 1'b0;
			end
			if (adv_done) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_done) begin
			rec_q <= rec;
		end
	end

	assign result_valid   = result_valid_q;
	assign cluster        = rec_q.cluster;
	assign sector_address = rec_q.sector_address;
	assign byte_count     = rec_q.byte_count;
	assign last           = rec_q.last;
	assign table_overrun  = rec_q.table_overrun;
	assign idle           = rec_q.idle;

	a_adv_holds: assert property (@(posedge clk) disable iff (!arst_n)
		adv_valid_s1 && result_valid_q && result_stall |=> adv_valid_s1)
		else $error("advance dropped while result held");

	a_done_shows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_done |=> result_valid_q)
		else $error("finished advance gave no result");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		adv_done && rec.last |=> !chain_q.active)
		else $error("chain still active after last record");

	a_overrun_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && rec_q.table_overrun |-> rec_q.last)
		else $error("overrun record not marked last");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && rec_q.idle |-> (rec_q.byte_count == 20'd0) && !rec_q.last
			&& (rec_q.cluster == 12'd0))
		else $error("idle record carries data");

endmodule

/* hdl/fcw_cfg.sv */
// configuration registers with precomputed cluster size and table bound
module fcw_cfg #(
	parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output fcw_pkg::geom_t      geom
);
	import fcw_pkg::*;

	localparam logic [LIMIT_W-1:0] TABLE_LIM = LIMIT_W'(TABLE_BYTES);
	localparam logic [LIMIT_W-1:0] RST_CSIZE = LIMIT_W'(int'(RST_BPS) * int'(RST_SPC));
	localparam logic [LIMIT_W-1:0] RST_RAW   = LIMIT_W'(int'(RST_BPS) * int'(RST_SPF));
	localparam logic [LIMIT_W-1:0] RST_LIMIT = (RST_RAW > TABLE_LIM) ? TABLE_LIM : RST_RAW;

	logic [15:0]        ds_q, ds_d;
	logic [7:0]         spc_q, spc_d;
	logic [12:0]        bps_q, bps_d;
	logic [7:0]         spf_q, spf_d;
	logic [LIMIT_W-1:0] csize_q, csize_d;
	logic [LIMIT_W-1:0] limit_q, limit_d;
	logic [LIMIT_W-1:0] fat_bytes;

	always_comb begin
		ds_d  = ds_q;
		spc_d = spc_q;
		bps_d = bps_q;
		spf_d = spf_q;
		if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_DATA_START: ds_d  = cfg_data;
				CFG_SPC:        spc_d = cfg_data[7:0];
				CFG_BPS:        bps_d = cfg_data[12:0];
				CFG_SPF:        spf_d = cfg_data[7:0];
				default:        ds_d  = ds_q;
			endcase
		end
	end

	// products follow the register values written at the same edge
	always_comb begin
		csize_d   = {8'b0, bps_d} * {13'b0, spc_d};
		fat_bytes = {8'b0, bps_d} * {13'b0, spf_d};
		limit_d   = (fat_bytes > TABLE_LIM) ? TABLE_LIM : fat_bytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_q    <= RST_DATA_START;
			spc_q   <= RST_SPC;
			bps_q   <= RST_BPS;
			spf_q   <= RST_SPF;
			csize_q <= RST_CSIZE;
			limit_q <= RST_LIMIT;
		end else begin
			ds_q    <= ds_d;
			spc_q   <= spc_d;
			bps_q   <= bps_d;
			spf_q   <= spf_d;
			csize_q <= csize_d;
			limit_q <= limit_d;
		end
	end

	assign geom.data_start   = ds_q;
	assign geom.spc          = spc_q;
	assign geom.cluster_size = csize_q;
	assign geom.limit        = limit_q;

endmodule

/* hdl/fcw_table.sv */
// fat byte store: one write port, two registered read ports for an entry pair
module fcw_table #(
	parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(TABLE_BYTES)-1:0] waddr,
	input  logic [7:0]                     wdata,
	input  logic [$clog2(TABLE_BYTES)-1:0] raddr,
	output logic [7:0]                     rd_lo,
	output logic [7:0]                     rd_hi
);
	localparam int AW = $clog2(TABLE_BYTES);

	logic [7:0]    store_q [TABLE_BYTES];
	logic [7:0]    rd_lo_s1, rd_hi_s1;
	logic [AW-1:0] raddr_hi;

	assign raddr_hi = raddr + AW'(1);

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_lo_s1 <= store_q[raddr];
		rd_hi_s1 <= store_q[raddr_hi];
	end

	assign rd_lo = rd_lo_s1;
	assign rd_hi = rd_hi_s1;

endmodule

/* hdl/fcw_step.sv */
// one advance: sector address, byte count, entry decode and next chain state
module fcw_step (
	input  fcw_pkg::chain_t  chain,
	input  fcw_pkg::geom_t   geom,
	input  logic [7:0]       rd_lo,
	input  logic [7:0]       rd_hi,
	output logic [12:0]      entry_index,
	output fcw_pkg::record_t rec,
	output fcw_pkg::chain_t  chain_next
);
	import fcw_pkg::*;

	logic signed [21:0]  diff_x, spc_x, prod;
	logic [31:0]         sector;
	logic [LIMIT_W-1:0]  take;
	logic [31:0]         rem_next;
	logic [13:0]         index_end;
	logic                overrun;
	logic [11:0]         entry;
	logic                last;

	// entry index is cluster * 1.5, rounded down
	assign entry_index = {1'b0, chain.cluster} + {2'b0, chain.cluster[11:1]};
	assign index_end   = {1'b0, entry_index} + 14'd1;

	always_comb begin
		// clusters 0 and 1 give a negative offset that wraps
		diff_x = $signed({10'b0, chain.cluster}) - 22'sd2;
		spc_x  = $signed({14'b0, geom.spc});
		prod   = diff_x * spc_x;
		sector = {16'b0, geom.data_start} + {{10{prod[21]}}, prod};

		if (chain.remaining < {11'b0, geom.cluster_size}) begin
			take = chain.remaining[LIMIT_W-1:0];
		end else begin
			take = geom.cluster_size;
		end
		rem_next = chain.remaining - {11'b0, take};

		overrun = {7'b0, index_end} >= geom.limit;

		if (chain.cluster[0]) begin
			entry = {rd_hi, rd_lo[7:4]};
		end else begin
			entry = {rd_hi[3:0], rd_lo};
		end

		last = overrun || (entry >= END_MARK) || (rem_next == 32'd0);

		if (chain.active) begin
			rec.cluster        = chain.cluster;
			rec.sector_address = sector;
			rec.byte_count     = (take > LIMIT_W'(COUNT_MAX)) ? COUNT_MAX : take[19:0];
			rec.last           = last;
			rec.table_overrun  = overrun;
			rec.idle           = 1'b0;
			chain_next.cluster   = overrun ? chain.cluster : entry;
			chain_next.remaining = rem_next;
			chain_next.active    = !last;
		end else begin
			rec        = '0;
			rec.idle   = 1'b1;
			chain_next = chain;
		end
	end

endmodule

/* tb/sv/fat12_cluster_chain_walker_tb.sv */
// self-checking testbench of the fat12 cluster chain walker
module fat12_cluster_chain_walker_tb;
	import fcw_pkg::*;

	localparam logic [1:0]  OP_NONE   = 2'd3;
	localparam logic [11:0] ENTRY_MAX = 12'hFFF;
	localparam int N_DIR = 26;

	localparam record_t NO_CHAIN = '{12'd0, 32'd0, 20'd0, 1'b0, 1'b0, 1'b1};
	localparam record_t UNTYPED  = '0;

	typedef struct packed {
		logic [1:0]  op;
		logic [12:0] addr;
		logic [7:0]  data;
		logic [11:0] first;
		logic [31:0] size;
		logic        typed;
		record_t     rec;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = CFG_DATA_START;
	logic [15:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  opcode = OP_LOAD;
	logic [12:0] table_address = '0;
	logic [7:0]  table_byte = '0;
	logic [11:0] first_cluster = '0;
	logic [31:0] file_length = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [11:0] cluster;
	logic [31:0] sector_address;
	logic [19:0] byte_count;
	logic        last;
	logic        table_overrun;
	logic        idle;

	// predictor state: table image, chain position and geometry registers
	logic [7:0]  fat_image [TABLE_BYTES_DEF];
	bit          loaded [TABLE_BYTES_DEF];
	logic [11:0] cur_cl = '0;
	logic [31:0] left_bytes = '0;
	bit          walking = 1'b0;
	logic [15:0] reg_ds = RST_DATA_START;
	logic [7:0]  reg_spc = RST_SPC;
	logic [12:0] reg_bps = RST_BPS;
	logic [7:0]  reg_spf = RST_SPF;

	record_t     records_due [$];
	record_t     want_rec;
	stim_row_t   dir_rows [N_DIR];

	int n_items = 0;
	int n_adv = 0;
	int n_records = 0;
	int n_errors = 0;
	int n_settings = 1;
	int hold_left = 0;
	bit held_once = 1'b0;

	fat12_cluster_chain_walker i_dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [31:0] table_bound();
		logic [31:0] lim;
		lim = 32'(reg_bps) * 32'(reg_spf);
		if (lim > TABLE_BYTES_DEF)
			lim = TABLE_BYTES_DEF;
		return lim;
	endfunction

	function automatic logic [31:0] cluster_bytes();
		return 32'(reg_bps) * 32'(reg_spc);
	endfunction

	// expected record of one beat, updates the table image and the chain state
	function automatic bit apply_item(input logic [1:0] op, input logic [12:0] a,
			input logic [7:0] d, input logic [11:0] fc, input logic [31:0] fs,
			output record_t rec);
		logic [31:0] take;
		logic [31:0] idx;
		logic [11:0] c;
		logic [7:0]  lo;
		logic [7:0]  hi;
		bit          over;
		bit          fin;
		rec = '0;
		case (op)
			OP_LOAD: begin
				fat_image[a] = d;
				loaded[a] = 1'b1;
				return 1'b0;
			end
			OP_START: begin
				cur_cl = fc;
				left_bytes = fs;
				walking = (fs != 0) && (fc < END_MARK);
				return 1'b0;
			end
			OP_ADVANCE: ;
			default: return 1'b0;
		endcase
		if (!walking) begin
			rec.idle = 1'b1;
			return 1'b1;
		end
		c = cur_cl;
		take = (left_bytes < cluster_bytes()) ? left_bytes : cluster_bytes();
		left_bytes = left_bytes - take;
		idx = 32'(c) + 32'(c >> 1);
		over = (idx + 1) >= table_bound();
		fin = over;
		if (!over) begin
			lo = fat_image[idx[12:0]];
			hi = fat_image[13'(idx + 1)];
			cur_cl = c[0] ? {hi, lo[7:4]} : {hi[3:0], lo};
			fin = (cur_cl >= END_MARK) || (left_bytes == 0);
		end
		if (fin)
			walking = 1'b0;
		rec.cluster = c;
		rec.sector_address = 32'(reg_ds) + (32'(c) - 32'd2) * 32'(reg_spc);
		rec.byte_count = (take > 32'(COUNT_MAX)) ? COUNT_MAX : take[19:0];
		rec.last = fin;
		rec.table_overrun = over;
		return 1'b1;
	endfunction

	function automatic logic [11:0] top_cluster();
		logic [31:0] c;
		if (table_bound() < 3)
			return '0;
		c = (table_bound() - 2) * 2 / 3;
		return (c > ENTRY_MAX) ? ENTRY_MAX : c[11:0];
	endfunction

	function automatic logic [11:0] pick_cluster();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65 && top_cluster() >= 2)
			return 12'($urandom_range(2, top_cluster()));
		if (r < 77)
			return 12'($urandom_range(END_MARK, ENTRY_MAX));
		if (r < 90)
			return 12'($urandom);
		return 12'($urandom_range(0, 1));
	endfunction

	function automatic logic [31:0] pick_size();
		logic [31:0] csz;
		int r;
		csz = cluster_bytes();
		r = $urandom_range(0, 99);
		if (r < 50 && csz != 0)
			return csz * $urandom_range(1, 10) - $urandom_range(0, csz - 1);
		if (r < 65)
			return $urandom;
		if (r < 72)
			return '1;
		if (r < 78)
			return '0;
		return $urandom_range(1, 2000);
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [12:0] a,
			input logic [7:0] d, input logic [11:0] fc, input logic [31:0] fs,
			input bit typed = 1'b0, input record_t typed_rec = '0);
		record_t rec;
		bit      took;
		while (!(n_items >= 300 && n_items < 450) && $urandom_range(0, 99) < 10) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		table_address <= a;
		table_byte <= d;
		first_cluster <= fc;
		file_length <= fs;
		// stall is stable at the falling edge before the accepting edge
		do begin
			@(negedge clk);
			took = !item_stall;
			@(posedge clk);
		end while (!took);
		if (op != OP_NONE)
			n_items++;
		if (op == OP_ADVANCE)
			n_adv++;
		if (apply_item(op, a, d, fc, fs, rec))
			records_due.push_back(typed ? typed_rec : rec);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (records_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_geometry(input logic [15:0] ds, input logic [7:0] spc,
			input logic [12:0] bps, input logic [7:0] spf);
		cfg_write <= 1'b1;
		cfg_index <= CFG_DATA_START;
		cfg_data <= ds;
		@(posedge clk);
		reg_ds = ds;
		cfg_index <= CFG_SPC;
		cfg_data <= 16'(spc);
		@(posedge clk);
		reg_spc = spc;
		cfg_index <= CFG_BPS;
		cfg_data <= 16'(bps);
		@(posedge clk);
		reg_bps = bps;
		cfg_index <= CFG_SPF;
		cfg_data <= 16'(spf);
		@(posedge clk);
		reg_spf = spf;
		cfg_write <= 1'b0;
		n_settings++;
	endtask

	// make sure the entry of the current cluster is loaded, often with a fresh link
	task automatic prime_entry();
		logic [31:0] idx;
		logic [11:0] nxt;
		logic [7:0]  lo;
		logic [7:0]  hi;
		if (!walking)
			return;
		idx = 32'(cur_cl) + 32'(cur_cl >> 1);
		if (idx + 1 >= table_bound())
			return;
		if (loaded[idx[12:0]] && loaded[13'(idx + 1)] && $urandom_range(0, 3) != 0)
			return;
		nxt = pick_cluster();
		lo = loaded[idx[12:0]] ? fat_image[idx[12:0]] : 8'($urandom);
		hi = loaded[13'(idx + 1)] ? fat_image[13'(idx + 1)] : 8'($urandom);
		if (cur_cl[0]) begin
			lo[7:4] = nxt[3:0];
			hi = nxt[11:4];
		end else begin
			lo = nxt[7:0];
			hi[3:0] = nxt[11:8];
		end
		send_item(OP_LOAD, idx[12:0], lo, 12'($urandom), $urandom);
		send_item(OP_LOAD, 13'(idx + 1), hi, 12'($urandom), $urandom);
	endtask

	task automatic walk_random(input int upto);
		int steps;
		bit live;
		while (n_items < upto) begin
			send_item(OP_START, 13'($urandom), 8'($urandom), pick_cluster(), pick_size());
			steps = $urandom_range(1, 24);
			live = 1'b1;
			while (live && steps > 0 && n_items < upto) begin
				if ($urandom_range(0, 99) < 12) begin
					case ($urandom_range(0, 2))
						0: send_item(OP_LOAD, 13'($urandom), 8'($urandom),
							12'($urandom), $urandom);
						1: send_item(OP_NONE, 13'($urandom), 8'($urandom),
							12'($urandom), $urandom);
						default: send_item(OP_START, 13'($urandom), 8'($urandom),
							12'($urandom), pick_size());
					endcase
				end
				if ($urandom_range(0, 99) < 2)
					settle();
				prime_entry();
				live = walking;
				send_item(OP_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom), $urandom);
				steps--;
			end
			if ($urandom_range(0, 99) < 30) begin
				prime_entry();
				send_item(OP_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom), $urandom);
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			n_errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// receiver: random stalls, one long hold-off that backs up the input
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (!held_once && n_records >= 120) begin
			held_once = 1'b1;
			hold_left = 400;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !(n_records >= 150 && n_records < 230) &&
				$urandom_range(0, 99) < 10;
		end
	end

	// a beat is taken at the next rising edge, so check it on the falling one
	always @(negedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (records_due.size() == 0) begin
				n_errors++;
				$display("%0t: record for cluster %0h with none expected", $time, cluster);
			end else begin
				want_rec = records_due.pop_front();
				compare_field("cluster", 32'(want_rec.cluster), 32'(cluster));
				compare_field("sector_address", want_rec.sector_address, sector_address);
				compare_field("byte_count", 32'(want_rec.byte_count), 32'(byte_count));
				compare_field("last", 32'(want_rec.last), 32'(last));
				compare_field("table_overrun", 32'(want_rec.table_overrun),
					32'(table_overrun));
				compare_field("idle", 32'(want_rec.idle), 32'(idle));
			end
			n_records++;
		end
	end

	initial begin
		int i;
		int ph;
		dir_rows = '{
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b1, NO_CHAIN},
			'{OP_NONE,    13'h1FFF,   8'hFF, 12'hFFF,  32'hFFFFFFFF, 1'b0, UNTYPED},
			'{OP_LOAD,    13'd0,      8'h03, 12'd0,    32'd0,        1'b0, UNTYPED},
			'{OP_LOAD,    13'd1,      8'hF0, 12'd0,    32'd0,        1'b0, UNTYPED},
			'{OP_LOAD,    13'd2,      8'hFF, 12'd0,    32'd0,        1'b0, UNTYPED},
			'{OP_LOAD,    13'd4,      8'hFF, 12'd0,    32'd0,        1'b0, UNTYPED},
			'{OP_LOAD,    13'd5,      8'hFF, 12'd0,    32'd0,        1'b0, UNTYPED},
			'{OP_LOAD,    13'h1FFF,   8'h00, 12'd0,    32'd0,        1'b0, UNTYPED},
			// cluster 0 wraps below the data area
			'{OP_START,   13'd0,      8'h00, 12'd0,    32'hFFFFFFFF, 1'b0, UNTYPED},
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b1,
				'{12'd0, 32'd31, 20'd512, 1'b0, 1'b0, 1'b0}},
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b1,
				'{12'd3, 32'd34, 20'd512, 1'b1, 1'b0, 1'b0}},
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b1, NO_CHAIN},
			'{OP_START,   13'd0,      8'h00, 12'd1,    32'd100,      1'b0, UNTYPED},
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b1,
				'{12'd1, 32'd32, 20'd100, 1'b1, 1'b0, 1'b0}},
			// starts that leave the chain inactive
			'{OP_START,   13'd0,      8'h00, 12'hFFF,  32'd5,        1'b0, UNTYPED},
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b1, NO_CHAIN},
			'{OP_START,   13'd0,      8'h00, 12'hFF8,  32'd1,        1'b0, UNTYPED},
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b1, NO_CHAIN},
			'{OP_START,   13'd0,      8'h00, 12'd2,    32'd0,        1'b0, UNTYPED},
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b1, NO_CHAIN},
			// entry index far beyond the table
			'{OP_START,   13'd0,      8'h00, 12'hFF7,  32'd1,        1'b0, UNTYPED},
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b1,
				'{12'hFF7, 32'd4118, 20'd1, 1'b1, 1'b1, 1'b0}},
			// restart of an active chain
			'{OP_START,   13'd0,      8'h00, 12'd2,    32'h80000000, 1'b0, UNTYPED},
			'{OP_START,   13'd0,      8'h00, 12'd0,    32'd600,      1'b0, UNTYPED},
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b0, UNTYPED},
			'{OP_ADVANCE, 13'd0,      8'h00, 12'd0,    32'd0,        1'b0, UNTYPED}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < N_DIR; i++)
			send_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].data,
				dir_rows[i].first, dir_rows[i].size, dir_rows[i].typed, dir_rows[i].rec);
		walk_random(n_items + 80);
		for (ph = 1; ph < 9; ph++) begin
			settle();
			repeat (4) @(posedge clk);
			case (ph)
				1: set_geometry(16'd0, 8'd1, 13'd1, 8'd1);
				2: set_geometry(16'hFFFF, 8'd128, 13'd4096, 8'd255);
				3: set_geometry(16'hFFFF, 8'hFF, 13'h1FFF, 8'hFF);
				4: set_geometry(16'd0, 8'd0, 13'd512, 8'd9);
				5: set_geometry(16'd1234, 8'd4, 13'd0, 8'd9);
				6: set_geometry(16'd100, 8'd8, 13'd512, 8'd0);
				default: set_geometry(16'($urandom), 8'($urandom_range(1, 128)),
					13'($urandom_range(1, 4096)), 8'($urandom_range(1, 255)));
			endcase
			walk_random(n_items + 90);
		end
		settle();
		repeat (8) @(posedge clk);
		$display("run covered %0d items (%0d advances) over %0d register settings",
			n_items, n_adv, n_settings);
		$display("%0d cluster records checked, %0d mismatches", n_records, n_errors);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
